@@ hdl/lfr_pkg.sv @@
// Shared types, constants and register codes of the lossy multichannel frame ring.
`default_nettype none
package lfr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CAP_W = 11;
  localparam int CHAN_W = 4;
  localparam int NUM_LANES = 8;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_RING_SLOTS = 1024;
  localparam int DEF_MAX_CHANNELS = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd2;
  localparam logic [CAP_W-1:0] CAP_REG_MAX = 11'd2047;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic accept;
    logic write;
    logic read;
  } lfr_mem_ctl_t;

  typedef struct packed {
    logic frame_valid;
    logic [CAP_W-1:0] frames_held;
    logic frames_lost;
  } lfr_status_t;

endpackage
`default_nettype wire

@@ hdl/lfr_channels.sv @@
// Valid/ready channel interfaces for frame requests and ring results.
`default_nettype none
interface lfr_request_if;
  logic valid;
  logic ready;
  logic command;
  logic signed [15:0] sample_in_0;
  logic signed [15:0] sample_in_1;
  logic signed [15:0] sample_in_2;
  logic signed [15:0] sample_in_3;
  logic signed [15:0] sample_in_4;
  logic signed [15:0] sample_in_5;
  logic signed [15:0] sample_in_6;
  logic signed [15:0] sample_in_7;

  modport source (
    output valid, command, sample_in_0, sample_in_1, sample_in_2, sample_in_3,
    output sample_in_4, sample_in_5, sample_in_6, sample_in_7,
    input ready
  );
  modport sink (
    input valid, command, sample_in_0, sample_in_1, sample_in_2, sample_in_3,
    input sample_in_4, sample_in_5, sample_in_6, sample_in_7,
    output ready
  );
endinterface

interface lfr_result_if;
  logic valid;
  logic ready;
  logic frame_valid;
  logic signed [15:0] sample_out_0;
  logic signed [15:0] sample_out_1;
  logic signed [15:0] sample_out_2;
  logic signed [15:0] sample_out_3;
  logic signed [15:0] sample_out_4;
  logic signed [15:0] sample_out_5;
  logic signed [15:0] sample_out_6;
  logic signed [15:0] sample_out_7;
  logic [10:0] frames_held;
  logic frames_lost;

  modport source (
    output valid, frame_valid, sample_out_0, sample_out_1, sample_out_2, sample_out_3,
    output sample_out_4, sample_out_5, sample_out_6, sample_out_7,
    output frames_held, frames_lost,
    input ready
  );
  modport sink (
    input valid, frame_valid, sample_out_0, sample_out_1, sample_out_2, sample_out_3,
    input sample_out_4, sample_out_5, sample_out_6, sample_out_7,
    input frames_held, frames_lost,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/lfr_ctrl.sv @@
// Ring control: configuration registers, positions, held count and lapped flag.
`default_nettype none
module lfr_ctrl #(
  parameter int RING_SLOTS = lfr_pkg::DEF_RING_SLOTS,
  parameter int MAX_CHANNELS = lfr_pkg::DEF_MAX_CHANNELS,
  parameter int PW = $clog2(RING_SLOTS)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [lfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lfr_pkg::CAP_W-1:0]        cfg_data,
  input  wire logic                             accept,
  input  wire logic                             command,
  output lfr_pkg::lfr_mem_ctl_t                 mem_ctl,
  output logic [PW-1:0]                         wr_addr,
  output logic [PW-1:0]                         rd_addr,
  output logic [lfr_pkg::CHAN_W-1:0]            chans,
  output lfr_pkg::lfr_status_t                  status
);

  localparam int AW = (PW + 1 > lfr_pkg::CAP_W) ? PW + 1 : lfr_pkg::CAP_W;
  localparam int CapLimitInt = (RING_SLOTS > 2047) ? 2047 : RING_SLOTS;
  localparam logic [lfr_pkg::CAP_W-1:0] CapLimit = lfr_pkg::CAP_W'(CapLimitInt);
  localparam logic [lfr_pkg::CHAN_W-1:0] ChanLimit = lfr_pkg::CHAN_W'(MAX_CHANNELS);

  logic [lfr_pkg::CAP_W-1:0] cap_reg;
  logic [lfr_pkg::CHAN_W-1:0] chan_reg;
  logic [PW-1:0] wpos;
  logic [PW-1:0] rpos;
  logic [lfr_pkg::CAP_W-1:0] held;
  logic lapped;

  logic [lfr_pkg::CAP_W-1:0] cap_nz;
  logic [lfr_pkg::CAP_W-1:0] cap;
  logic [lfr_pkg::CHAN_W-1:0] chan_nz;
  logic [AW-1:0] wpos_inc;
  logic [AW-1:0] rpos_inc;
  logic [PW-1:0] wpos_next;
  logic [PW-1:0] rpos_next;
  logic is_push;
  logic full;

  always_comb begin
    cap_nz = (cap_reg == '0) ? lfr_pkg::CAP_W'(1) : cap_reg;
    cap = (cap_nz > CapLimit) ? CapLimit : cap_nz;
    chan_nz = (chan_reg == '0) ? lfr_pkg::CHAN_W'(1) : chan_reg;
    chans = (chan_nz > ChanLimit) ? ChanLimit : chan_nz;
    wpos_inc = AW'(wpos) + AW'(1);
    rpos_inc = AW'(rpos) + AW'(1);
    wpos_next = (wpos_inc >= AW'(cap)) ? '0 : wpos_inc[PW-1:0];
    rpos_next = (rpos_inc >= AW'(cap)) ? '0 : rpos_inc[PW-1:0];
    is_push = (command == lfr_pkg::CMD_PUSH);
    full = (held >= cap);
    mem_ctl.accept = accept;
    mem_ctl.write = accept && is_push;
    mem_ctl.read = accept && !is_push && (held != '0);
    wr_addr = wpos;
    rd_addr = rpos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= lfr_pkg::CAP_RESET;
      chan_reg <= lfr_pkg::CHAN_RESET;
      wpos <= '0;
      rpos <= '0;
      held <= '0;
      lapped <= 1'b0;
      status <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lfr_pkg::REG_CAPACITY: begin
          cap_reg <= cfg_data;
          wpos <= '0;
          rpos <= '0;
          held <= '0;
          lapped <= 1'b0;
        end
        lfr_pkg::REG_CHANNELS: begin
          chan_reg <= cfg_data[lfr_pkg::CHAN_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (is_push) begin
        wpos <= wpos_next;
        status.frame_valid <= 1'b0;
        status.frames_lost <= 1'b0;
        if (full) begin
          rpos <= rpos_next;
          lapped <= 1'b1;
          status.frames_held <= held;
        end else begin
          held <= held + lfr_pkg::CAP_W'(1);
          status.frames_held <= held + lfr_pkg::CAP_W'(1);
        end
      end else begin
        status.frames_lost <= lapped;
        lapped <= 1'b0;
        if (held != '0) begin
          rpos <= rpos_next;
          held <= held - lfr_pkg::CAP_W'(1);
          status.frame_valid <= 1'b1;
          status.frames_held <= held - lfr_pkg::CAP_W'(1);
        end else begin
          status.frame_valid <= 1'b0;
          status.frames_held <= held;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/lfr_lane.sv @@
// One sample lane: its slice of the frame store and its registered read data.
`default_nettype none
module lfr_lane #(
  parameter int RING_SLOTS = lfr_pkg::DEF_RING_SLOTS,
  parameter int LANE = 0,
  parameter int PW = $clog2(RING_SLOTS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lfr_pkg::lfr_mem_ctl_t mem_ctl,
  input  wire logic [lfr_pkg::CHAN_W-1:0] chans,
  input  wire logic [PW-1:0]         wr_addr,
  input  wire logic [PW-1:0]         rd_addr,
  input  wire lfr_pkg::sample_t      sample_in,
  output lfr_pkg::sample_t           sample_out
);

  lfr_pkg::sample_t mem [RING_SLOTS];
  lfr_pkg::sample_t rd_data;
  logic out_on;
  logic lane_on;

  assign lane_on = (lfr_pkg::CHAN_W'(LANE) < chans);
  assign sample_out = out_on ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (mem_ctl.write) begin
      mem[wr_addr] <= lane_on ? sample_in : '0;
    end
    if (mem_ctl.read) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_on <= 1'b0;
    end else if (mem_ctl.accept) begin
      out_on <= mem_ctl.read && lane_on;
    end
  end

endmodule
`default_nettype wire

@@ hdl/lossy_multichannel_frame_ring.sv @@
// Top level of the lossy multichannel frame ring.
// A request transfer either pushes one frame of up to eight 16-bit samples
// or pops the oldest frame held. Pushes never block: on a full ring the
// oldest frame is overwritten and the next pop reports frames_lost.
// Every request produces exactly one result transfer carrying frame_valid,
// the popped samples (zero for unused lanes or an empty ring), frames_held
// and frames_lost.
// Each lane owns one bank of the frame store, so a whole frame is written or
// read together; the lane outputs are merged into one result.
// The result is registered and appears in the cycle after its request is
// accepted; one request is taken per cycle unless the receiver stalls.
// The result register holds while the receiver stalls; a new request is
// taken only when that register is empty or being emptied in the same cycle.
// Reset empties the ring and loads capacity 1024 and two channels; stored
// samples are not cleared. Writing the capacity register also empties the
// ring. Configuration must be written through cfg_write, cfg_index and
// cfg_data only while no request is in flight; the block does not check it.
`default_nettype none
module lossy_multichannel_frame_ring #(
  parameter int RING_SLOTS = lfr_pkg::DEF_RING_SLOTS,
  parameter int MAX_CHANNELS = lfr_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lfr_pkg::CAP_W-1:0]     cfg_data,
  lfr_request_if.sink                        request,
  lfr_result_if.source                       result
);

  localparam int PW = $clog2(RING_SLOTS);

  lfr_pkg::lfr_mem_ctl_t mem_ctl;
  lfr_pkg::lfr_status_t status;
  logic [PW-1:0] wr_addr;
  logic [PW-1:0] rd_addr;
  logic [lfr_pkg::CHAN_W-1:0] chans;
  logic accept;
  logic out_valid;
  lfr_pkg::sample_t in_samples [lfr_pkg::NUM_LANES];
  lfr_pkg::sample_t out_samples [lfr_pkg::NUM_LANES];

  assign request.ready = !out_valid || result.ready;
  assign accept = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  lfr_ctrl #(
    .RING_SLOTS(RING_SLOTS),
    .MAX_CHANNELS(MAX_CHANNELS),
    .PW(PW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .accept(accept),
    .command(request.command),
    .mem_ctl(mem_ctl),
    .wr_addr(wr_addr),
    .rd_addr(rd_addr),
    .chans(chans),
    .status(status)
  );

  assign in_samples[0] = request.sample_in_0;
  assign in_samples[1] = request.sample_in_1;
  assign in_samples[2] = request.sample_in_2;
  assign in_samples[3] = request.sample_in_3;
  assign in_samples[4] = request.sample_in_4;
  assign in_samples[5] = request.sample_in_5;
  assign in_samples[6] = request.sample_in_6;
  assign in_samples[7] = request.sample_in_7;

  for (genvar g = 0; g < lfr_pkg::NUM_LANES; g++) begin : g_lane
    if (g < MAX_CHANNELS) begin : g_on
      lfr_lane #(
        .RING_SLOTS(RING_SLOTS),
        .LANE(g),
        .PW(PW)
      ) u_lane (
        .clk(clk),
        .rst(rst),
        .mem_ctl(mem_ctl),
        .chans(chans),
        .wr_addr(wr_addr),
        .rd_addr(rd_addr),
        .sample_in(in_samples[g]),
        .sample_out(out_samples[g])
      );
    end else begin : g_off
      assign out_samples[g] = '0;
    end
  end

  assign result.valid = out_valid;
  assign result.frame_valid = status.frame_valid;
  assign result.frames_held = status.frames_held;
  assign result.frames_lost = status.frames_lost;
  assign result.sample_out_0 = out_samples[0];
  assign result.sample_out_1 = out_samples[1];
  assign result.sample_out_2 = out_samples[2];
  assign result.sample_out_3 = out_samples[3];
  assign result.sample_out_4 = out_samples[4];
  assign result.sample_out_5 = out_samples[5];
  assign result.sample_out_6 = out_samples[6];
  assign result.sample_out_7 = out_samples[7];

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted request produced no result");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    accept && (request.command == lfr_pkg::CMD_PUSH)
    |=> !result.frame_valid && !result.frames_lost)
    else $error("push result carries a frame or a loss flag");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.frame_valid
    |-> (result.sample_out_0 == '0) && (result.sample_out_1 == '0) &&
        (result.sample_out_2 == '0) && (result.sample_out_3 == '0) &&
        (result.sample_out_4 == '0) && (result.sample_out_5 == '0) &&
        (result.sample_out_6 == '0) && (result.sample_out_7 == '0))
    else $error("result without a frame has nonzero samples");

endmodule
`default_nettype wire

@@ verif/lfr_ring_checker.sv @@
// Checker for the frame ring: predicts every result from observed transfers and compares.
`default_nettype none
module lfr_ring_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lfr_pkg::CAP_W-1:0]     cfg_data,
  lfr_request_if                             request,
  lfr_result_if                              result,
  output int                                 fail_count,
  output int                                 pending_results
);

  localparam int RING_SLOTS = lfr_pkg::DEF_RING_SLOTS;
  localparam int POS_W = $clog2(RING_SLOTS);

  typedef logic [lfr_pkg::NUM_LANES-1:0][lfr_pkg::SAMPLE_W-1:0] lane_set_t;

  typedef struct packed {
    logic frame_valid;
    lane_set_t samples;
    logic [lfr_pkg::CAP_W-1:0] frames_held;
    logic frames_lost;
  } ring_outcome_t;

  logic [lfr_pkg::SAMPLE_W-1:0] frame_store [RING_SLOTS][lfr_pkg::NUM_LANES];
  logic [POS_W-1:0] write_pos;
  logic [POS_W-1:0] read_pos;
  logic [lfr_pkg::CAP_W-1:0] held_frames;
  logic lapped;
  logic [lfr_pkg::CAP_W-1:0] capacity_reg;
  logic [lfr_pkg::CHAN_W-1:0] channels_reg;

  ring_outcome_t expected_outcomes [$];
  int errors = 0;
  int waiting = 0;

  assign fail_count = errors;
  assign pending_results = waiting;

  function automatic int live_capacity();
    int cap;
    cap = capacity_reg;
    if (cap == 0) cap = 1;
    if (cap > RING_SLOTS) cap = RING_SLOTS;
    return cap;
  endfunction

  function automatic int live_channels();
    int chans;
    chans = channels_reg;
    if (chans == 0) chans = 1;
    if (chans > lfr_pkg::NUM_LANES) chans = lfr_pkg::NUM_LANES;
    return chans;
  endfunction

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos, input int cap);
    int bumped;
    bumped = int'(pos) + 1;
    return (bumped >= cap) ? '0 : POS_W'(bumped);
  endfunction

  function automatic void empty_ring();
    write_pos = '0;
    read_pos = '0;
    held_frames = '0;
    lapped = 1'b0;
  endfunction

  function automatic ring_outcome_t step_ring(input logic cmd, input lane_set_t lanes_in);
    ring_outcome_t outcome;
    int cap;
    int chans;
    int lane;
    cap = live_capacity();
    chans = live_channels();
    outcome = '0;
    if (cmd == lfr_pkg::CMD_PUSH) begin
      for (lane = 0; lane < lfr_pkg::NUM_LANES; lane++) begin
        frame_store[write_pos][lane] = (lane < chans) ? lanes_in[lane] : '0;
      end
      write_pos = next_pos(write_pos, cap);
      if (int'(held_frames) >= cap) begin
        read_pos = next_pos(read_pos, cap);
        lapped = 1'b1;
      end else begin
        held_frames = held_frames + 1'b1;
      end
      outcome.frames_held = held_frames;
    end else begin
      if (held_frames != 0) begin
        outcome.frame_valid = 1'b1;
        for (lane = 0; lane < lfr_pkg::NUM_LANES; lane++) begin
          if (lane < chans) outcome.samples[lane] = frame_store[read_pos][lane];
        end
        read_pos = next_pos(read_pos, cap);
        held_frames = held_frames - 1'b1;
      end
      outcome.frames_held = held_frames;
      outcome.frames_lost = lapped;
      lapped = 1'b0;
    end
    return outcome;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    ring_outcome_t want;
    lane_set_t got_samples;
    lane_set_t pushed;
    int lane;
    if (rst) begin
      empty_ring();
      capacity_reg = lfr_pkg::CAP_RESET;
      channels_reg = lfr_pkg::CHAN_RESET;
      expected_outcomes.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == lfr_pkg::REG_CAPACITY) begin
          capacity_reg = cfg_data;
          empty_ring();
        end else if (cfg_index == lfr_pkg::REG_CHANNELS) begin
          channels_reg = cfg_data[lfr_pkg::CHAN_W-1:0];
        end
      end
      if (result.valid && result.ready) begin
        if (expected_outcomes.size() == 0) begin
          errors++;
          $error("result transfer with no request waiting for it");
        end else begin
          want = expected_outcomes.pop_front();
          got_samples = {result.sample_out_7, result.sample_out_6, result.sample_out_5,
                         result.sample_out_4, result.sample_out_3, result.sample_out_2,
                         result.sample_out_1, result.sample_out_0};
          check_field("frame_valid", want.frame_valid, result.frame_valid);
          for (lane = 0; lane < lfr_pkg::NUM_LANES; lane++) begin
            check_field($sformatf("sample_out_%0d", lane), int'($signed(want.samples[lane])),
                        int'($signed(got_samples[lane])));
          end
          check_field("frames_held", want.frames_held, result.frames_held);
          check_field("frames_lost", want.frames_lost, result.frames_lost);
        end
      end
      if (request.valid && request.ready) begin
        pushed = {request.sample_in_7, request.sample_in_6, request.sample_in_5,
                  request.sample_in_4, request.sample_in_3, request.sample_in_2,
                  request.sample_in_1, request.sample_in_0};
        expected_outcomes.push_back(step_ring(request.command, pushed));
      end
    end
    waiting = expected_outcomes.size();
  end
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench top: drives frame pushes, pops and register writes into the frame ring.
`default_nettype none
module tb;

  localparam logic [lfr_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [lfr_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int RANDOM_ITEMS = 400;

  typedef logic [lfr_pkg::NUM_LANES-1:0][lfr_pkg::SAMPLE_W-1:0] lane_set_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lfr_pkg::CAP_W-1:0] cfg_data;
  int fail_count;
  int pending_results;
  bit calm = 1'b0;

  lfr_request_if request ();
  lfr_result_if result ();

  lossy_multichannel_frame_ring dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .result    (result)
  );

  lfr_ring_checker ring_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .request         (request),
    .result          (result),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  function automatic lane_set_t random_lanes();
    lane_set_t lanes;
    int lane;
    for (lane = 0; lane < lfr_pkg::NUM_LANES; lane++) begin
      lanes[lane] = lfr_pkg::SAMPLE_W'($urandom());
    end
    return lanes;
  endfunction

  function automatic logic [lfr_pkg::CAP_W-1:0] pick_capacity();
    case ($urandom_range(7))
      0: return '0;
      1: return lfr_pkg::CAP_W'(1);
      2: return lfr_pkg::CAP_W'(2);
      3, 4: return lfr_pkg::CAP_W'($urandom_range(3, 12));
      5: return lfr_pkg::CAP_W'($urandom_range(13, 64));
      6: return ($urandom_range(1) == 0) ? lfr_pkg::CAP_REG_MAX :
                lfr_pkg::CAP_W'(lfr_pkg::DEF_RING_SLOTS + 1);
      default: return lfr_pkg::CAP_W'($urandom());
    endcase
  endfunction

  task automatic send_frame(input logic cmd, input lane_set_t lanes);
    while (!calm && $urandom_range(99) < 7) begin
      request.valid <= 1'b0;
      @(posedge clk);
    end
    request.valid <= 1'b1;
    request.command <= cmd;
    request.sample_in_0 <= lanes[0];
    request.sample_in_1 <= lanes[1];
    request.sample_in_2 <= lanes[2];
    request.sample_in_3 <= lanes[3];
    request.sample_in_4 <= lanes[4];
    request.sample_in_5 <= lanes[5];
    request.sample_in_6 <= lanes[6];
    request.sample_in_7 <= lanes[7];
    do @(negedge clk); while (!request.ready);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [lfr_pkg::CFG_IDX_W-1:0] index,
                           input logic [lfr_pkg::CAP_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    int guard = 0;
    request.valid <= 1'b0;
    do begin
      @(negedge clk);
      guard++;
    end while (pending_results != 0 && guard < 2000);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int sent;
    int push_pct;
    int phase_len;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= lfr_pkg::REG_CAPACITY;
    cfg_data <= '0;
    request.valid <= 1'b0;
    request.command <= lfr_pkg::CMD_PUSH;
    request.sample_in_0 <= '0;
    request.sample_in_1 <= '0;
    request.sample_in_2 <= '0;
    request.sample_in_3 <= '0;
    request.sample_in_4 <= '0;
    request.sample_in_5 <= '0;
    request.sample_in_6 <= '0;
    request.sample_in_7 <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: empty pops and the sample extremes on two channels.
    send_frame(lfr_pkg::CMD_POP, random_lanes());
    send_frame(lfr_pkg::CMD_PUSH, lane_set_t'({lfr_pkg::NUM_LANES{16'h8000}}));
    send_frame(lfr_pkg::CMD_PUSH, lane_set_t'({lfr_pkg::NUM_LANES{16'h7fff}}));
    send_frame(lfr_pkg::CMD_POP, random_lanes());
    send_frame(lfr_pkg::CMD_POP, random_lanes());
    send_frame(lfr_pkg::CMD_POP, random_lanes());

    // A two-frame ring overwritten by a third push.
    settle();
    write_reg(lfr_pkg::REG_CHANNELS, lfr_pkg::CAP_W'(8));
    write_reg(lfr_pkg::REG_CAPACITY, lfr_pkg::CAP_W'(2));
    send_frame(lfr_pkg::CMD_PUSH, lane_set_t'({lfr_pkg::NUM_LANES{16'hffff}}));
    send_frame(lfr_pkg::CMD_PUSH, '0);
    send_frame(lfr_pkg::CMD_PUSH, random_lanes());
    send_frame(lfr_pkg::CMD_POP, random_lanes());
    send_frame(lfr_pkg::CMD_POP, random_lanes());
    send_frame(lfr_pkg::CMD_POP, random_lanes());

    // Channel count changes while frames are held.
    send_frame(lfr_pkg::CMD_PUSH, random_lanes());
    send_frame(lfr_pkg::CMD_PUSH, random_lanes());
    settle();
    write_reg(lfr_pkg::REG_CHANNELS, lfr_pkg::CAP_W'(3));
    send_frame(lfr_pkg::CMD_POP, random_lanes());
    settle();
    write_reg(lfr_pkg::REG_CHANNELS, lfr_pkg::CAP_W'(15));
    send_frame(lfr_pkg::CMD_POP, random_lanes());
    settle();
    write_reg(lfr_pkg::REG_CHANNELS, '0);
    send_frame(lfr_pkg::CMD_PUSH, random_lanes());
    settle();
    write_reg(lfr_pkg::REG_CHANNELS, lfr_pkg::CAP_W'(11'h7f5));
    send_frame(lfr_pkg::CMD_POP, random_lanes());

    // Capacity zero acts as one; writes to unused indexes change nothing.
    settle();
    write_reg(lfr_pkg::REG_CAPACITY, '0);
    write_reg(REG_SPARE_2, lfr_pkg::CAP_W'(5));
    write_reg(REG_SPARE_3, lfr_pkg::CAP_REG_MAX);
    send_frame(lfr_pkg::CMD_PUSH, random_lanes());
    send_frame(lfr_pkg::CMD_PUSH, random_lanes());
    send_frame(lfr_pkg::CMD_POP, random_lanes());
    send_frame(lfr_pkg::CMD_POP, random_lanes());
    settle();
    write_reg(lfr_pkg::REG_CAPACITY, lfr_pkg::CAP_REG_MAX);
    send_frame(lfr_pkg::CMD_PUSH, random_lanes());
    send_frame(lfr_pkg::CMD_POP, random_lanes());

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(99) < 70) write_reg(lfr_pkg::REG_CAPACITY, pick_capacity());
      write_reg(lfr_pkg::REG_CHANNELS, lfr_pkg::CAP_W'($urandom()));
      if ($urandom_range(9) == 0) begin
        write_reg(($urandom_range(1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                  lfr_pkg::CAP_W'($urandom()));
      end
      push_pct = $urandom_range(20, 85);
      phase_len = $urandom_range(15, 50);
      repeat (phase_len) begin
        calm = (sent >= 200 && sent < 320);
        send_frame(($urandom_range(99) < push_pct) ? lfr_pkg::CMD_PUSH : lfr_pkg::CMD_POP,
                   random_lanes());
        sent++;
      end
    end
    calm = 1'b0;

    // Overfill a mid-sized ring so both positions wrap more than once.
    settle();
    write_reg(lfr_pkg::REG_CAPACITY, lfr_pkg::CAP_W'(24));
    write_reg(lfr_pkg::REG_CHANNELS, lfr_pkg::CAP_W'($urandom_range(1, 8)));
    repeat (60) send_frame(lfr_pkg::CMD_PUSH, random_lanes());
    repeat (12) send_frame(lfr_pkg::CMD_POP, random_lanes());

    settle();
    if (pending_results != 0) begin
      $error("%0d expected results never arrived", pending_results);
    end
    if (fail_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ lossy_multichannel_frame_ring.f @@
hdl/lfr_pkg.sv
hdl/lfr_channels.sv
hdl/lfr_ctrl.sv
hdl/lfr_lane.sv
hdl/lossy_multichannel_frame_ring.sv
verif/lfr_ring_checker.sv
verif/tb.sv
